>>> hdl/assert_macros.svh
// Assertion macros used by the RTL core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed: property violated");
// Condition must never be true outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

>>> hdl/eioc_pkg.sv
// Types, constants and fixed-point helpers of the ease-in/ease-out curve core
package eioc_pkg;

    // Q format of time, progress and ease fractions
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int CFG_W     = FRAC_BITS;
    localparam int IDX_W     = 8;
    localparam int TDATA_W   = ((T_W + 7) / 8) * 8;

    localparam logic [T_W-1:0]   ONE_VAL  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CFG_W-1:0] HALF_VAL = {1'b1, {(CFG_W-1){1'b0}}};

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_IDX_EASE_IN  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_IDX_EASE_OUT = IDX_W'(1);

    // Phase and sine values are Q1.30
    localparam int Q_BITS = 30;
    localparam int PH_W   = Q_BITS + 1;
    localparam logic [PH_W-1:0] Q30_VAL = {1'b1, {Q_BITS{1'b0}}};

    // Phase divider: one integer step plus one step per fraction bit
    localparam int NUM_W = CFG_W + 1;
    localparam int DIV_N = Q_BITS + 1;

    // Distances carry FRAC_BITS+DIST_EXT fraction bits
    localparam int DIST_EXT = 14;
    localparam int DIST_W   = FRAC_BITS + DIST_EXT + 1;
    localparam int ACCEL_SH = 10;
    localparam int EASE_SH  = 16;

    // 2/pi in Q24
    localparam int K_W = 24;
    localparam logic [K_W-1:0] K_2PI = 24'd10680707;

    // Progress divider
    localparam int FDIV_N = FRAC_BITS + 1;
    localparam int N_W    = DIST_W + FRAC_BITS;

    // Odd Taylor polynomial of sin(x*pi/2), Horner form over x^2
    localparam int ACC_W    = 32;
    localparam int HORNER_N = 6;
    localparam logic signed [ACC_W-1:0] HORNER_TOP = 32'sd61;
    localparam logic signed [ACC_W-1:0] SIN_ADD [HORNER_N] = '{
        -32'sd3864, 32'sd172272, -32'sd5026995,
        32'sd85569306, -32'sd693598668, 32'sd1686629713
    };

    typedef enum logic [1:0] {
        SEG_MID,
        SEG_IN,
        SEG_OUT
    } t_seg;

    // Side data that travels with an item up to the distance stage
    typedef struct packed {
        t_seg              seg;
        logic [CFG_W-1:0]  scale;
        logic [DIST_W-1:0] base;
    } t_side;

    // Q30 product truncated toward zero; v is never negative
    function automatic logic signed [ACC_W-1:0] mul_q30(
        input logic signed [ACC_W-1:0] acc,
        input logic [PH_W-1:0]         v
    );
        logic                        neg;
        logic [ACC_W-1:0]            absv;
        logic [ACC_W+PH_W-2:0]       prod;
        logic [ACC_W-1:0]            q;
        neg  = acc[ACC_W-1];
        absv = neg ? -acc : acc;
        prod = absv[ACC_W-2:0] * v;
        q    = {1'b0, prod[Q_BITS+ACC_W-2:Q_BITS]};
        return neg ? $signed(-q) : $signed(q);
    endfunction

endpackage

>>> hdl/ease_in_out_curve_core.sv
// Pipelined sinusoidal ease-in/ease-out curve with a linear middle segment
//
// Input items on s_axis carry a normalized time (Q1.16, saturated to 1.0);
// result items on m_axis carry the eased progress (Q1.16, 0..1.0), one per item.
// The ease-in and ease-out fractions (Q0.16, clamped to one half) are written
// on the cfg channel: index 0 ease-in, index 1 ease-out, others ignored.
// o_cfg_ready is always high; write only while no item is in flight.
//
// Throughput is one item per cycle unless the receiver stalls. The depth is set
// by the two bit-serial dividers (31 steps for the sine phase, 17 steps for
// the progress normalization) and the eight multiplier stages of the sine
// polynomial.
//
// Reset clears the ease fractions to zero (a straight line) and empties the
// pipeline. When the receiver holds m_axis_tready low with a result waiting,
// the whole pipeline freezes and s_axis_tready drops; nothing is lost.
`include "assert_macros.svh"

module ease_in_out_curve_core import eioc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // input items
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // [16:0] time_fraction
    // result items
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata   // [16:0] progress
);

    localparam int ST_DIV = 2;
    localparam int ST_X   = ST_DIV + DIV_N;
    localparam int ST_X2  = ST_X + 1;
    localparam int ST_H   = ST_X2 + 1;
    localparam int ST_S   = ST_H + HORNER_N;
    localparam int ST_W   = ST_S + 1;
    localparam int ST_E1  = ST_W + 1;
    localparam int ST_E2  = ST_E1 + 1;
    localparam int ST_D   = ST_E2 + 1;
    localparam int ST_FD  = ST_D + 1;
    localparam int ST_OUT = ST_FD + FDIV_N;
    localparam int NST    = ST_OUT + 1;

    logic              ce;
    logic [NST-1:0]    r_vld;

    logic [CFG_W-1:0]  r_ease_in;
    logic [CFG_W-1:0]  r_ease_out;
    logic [CFG_W-1:0]  w_a;
    logic [CFG_W-1:0]  w_b;
    logic [CFG_W+K_W-1:0] w_accel_p;
    logic [CFG_W+K_W-1:0] w_decel_p;
    logic [T_W-1:0]    w_lin_base;
    logic [DIST_W-1:0] r_accel;
    logic [DIST_W-1:0] r_decel;
    logic [DIST_W-1:0] r_lin;
    logic [DIST_W-1:0] r_total;

    logic [T_W-1:0]    w_t_in;
    logic [T_W-1:0]    r0_t;

    logic              w_in_seg;
    logic              w_out_seg;
    logic [T_W-1:0]    w_out_start;
    logic [T_W-1:0]    w_t_out;
    logic [T_W-1:0]    w_t_mid;
    logic [CFG_W-1:0]  n1_num;
    logic [CFG_W-1:0]  n1_den;
    t_side             n1_side;
    logic [CFG_W-1:0]  r1_num;
    logic [CFG_W-1:0]  r1_den;
    t_side             r1_side;

    logic [NUM_W-1:0]  r_dv_rem  [DIV_N];
    logic [CFG_W-1:0]  r_dv_den  [DIV_N];
    logic [PH_W-1:0]   r_dv_q    [DIV_N];
    t_side             r_dv_side [DIV_N];

    logic [PH_W-1:0]   r_x;
    t_side             r_x_side;
    logic [2*PH_W-1:0] w_xx;
    logic [PH_W-1:0]   r_x2;
    logic [PH_W-1:0]   r_x2_x;
    t_side             r_x2_side;

    logic signed [ACC_W-1:0] r_hacc  [HORNER_N];
    logic [PH_W-1:0]         r_hx    [HORNER_N];
    logic [PH_W-1:0]         r_hx2   [HORNER_N];
    t_side                   r_hside [HORNER_N];

    logic signed [ACC_W-1:0] w_s_full;
    logic [PH_W-1:0]   r_s;
    t_side             r_s_side;
    logic [PH_W-1:0]   r_v;
    t_side             r_v_side;
    logic [CFG_W+PH_W-1:0] w_e1p;
    logic [DIST_W-1:0] r_e1;
    t_side             r_e1_side;
    logic [DIST_W+K_W-1:0] w_e2p;
    logic [DIST_W-1:0] r_e2;
    t_side             r_e2_side;
    logic [DIST_W-1:0] r_dist;

    logic [N_W-1:0]    w_num;
    logic [DIST_W-1:0] r_fd_rem [FDIV_N];
    logic [FDIV_N-1:0] r_fd_nlo [FDIV_N];
    logic [FDIV_N-1:0] r_fd_q   [FDIV_N];
    logic [T_W-1:0]    r_out;

    // Pipeline advances unless a result waits on a stalled receiver
    assign ce            = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ease_in  <= '0;
            r_ease_out <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_EASE_IN:  r_ease_in  <= i_cfg_data;
                CFG_IDX_EASE_OUT: r_ease_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp fractions and derive segment lengths
    assign w_a        = (r_ease_in  > HALF_VAL) ? HALF_VAL : r_ease_in;
    assign w_b        = (r_ease_out > HALF_VAL) ? HALF_VAL : r_ease_out;
    assign w_accel_p  = w_a * K_2PI;
    assign w_decel_p  = w_b * K_2PI;
    assign w_lin_base = ONE_VAL - {1'b0, w_a} - {1'b0, w_b};

    always_ff @(posedge i_clk) begin
        r_accel <= DIST_W'(w_accel_p >> ACCEL_SH);
        r_decel <= DIST_W'(w_decel_p >> ACCEL_SH);
        r_lin   <= {w_lin_base, {DIST_EXT{1'b0}}};
        r_total <= r_accel + r_lin + r_decel;
    end

    // Stage 0: capture and saturate time
    assign w_t_in = (s_axis_tdata[T_W-1:0] > ONE_VAL) ? ONE_VAL : s_axis_tdata[T_W-1:0];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_t <= w_t_in;
        end
    end

    // Stage 1: pick segment, divider operands and base distance
    assign w_out_start = ONE_VAL - {1'b0, w_b};
    assign w_in_seg    = r0_t < {1'b0, w_a};
    assign w_out_seg   = r0_t > w_out_start;
    assign w_t_out     = r0_t - w_out_start;
    assign w_t_mid     = r0_t - {1'b0, w_a};

    always_comb begin
        n1_side.scale = w_in_seg ? w_a : w_b;
        if (w_in_seg) begin
            n1_side.seg  = SEG_IN;
            n1_side.base = '0;
            n1_num       = r0_t[CFG_W-1:0];
            n1_den       = w_a;
        end else if (w_out_seg) begin
            n1_side.seg  = SEG_OUT;
            n1_side.base = r_accel + r_lin;
            n1_num       = w_t_out[CFG_W-1:0];
            n1_den       = w_b;
        end else begin
            n1_side.seg  = SEG_MID;
            n1_side.base = r_accel + {w_t_mid, {DIST_EXT{1'b0}}};
            n1_num       = '0;
            n1_den       = CFG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_num  <= n1_num;
            r1_den  <= n1_den;
            r1_side <= n1_side;
        end
    end

    // Phase divider: u = num * 2^30 / den, one quotient bit per stage
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [NUM_W-1:0] w_rem_in;
        logic [NUM_W-1:0] w_sh;
        logic [CFG_W-1:0] w_den;
        logic [PH_W-1:0]  w_q_in;
        t_side            w_side;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = {1'b0, r1_num};
            assign w_den    = r1_den;
            assign w_q_in   = '0;
            assign w_side   = r1_side;
            assign w_sh     = w_rem_in;
        end else begin : g_next
            assign w_rem_in = r_dv_rem[k-1];
            assign w_den    = r_dv_den[k-1];
            assign w_q_in   = r_dv_q[k-1];
            assign w_side   = r_dv_side[k-1];
            assign w_sh     = {w_rem_in[NUM_W-2:0], 1'b0};
        end

        assign w_ge = w_sh >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dv_rem[k]  <= w_ge ? (w_sh - {1'b0, w_den}) : w_sh;
                r_dv_q[k]    <= {w_q_in[PH_W-2:0], w_ge};
                r_dv_den[k]  <= w_den;
                r_dv_side[k] <= w_side;
            end
        end
    end

    // Sine argument: ease-in uses cos(u) = sin(1 - u)
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x      <= (r_dv_side[DIV_N-1].seg == SEG_IN) ?
                        (Q30_VAL - r_dv_q[DIV_N-1]) : r_dv_q[DIV_N-1];
            r_x_side <= r_dv_side[DIV_N-1];
        end
    end

    // Square of the argument
    assign w_xx = r_x * r_x;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x2      <= w_xx[Q_BITS+PH_W-1:Q_BITS];
            r_x2_x    <= r_x;
            r_x2_side <= r_x_side;
        end
    end

    // Horner steps, one multiply per stage
    for (genvar h = 0; h < HORNER_N; h++) begin : g_horner
        logic signed [ACC_W-1:0] w_acc_in;
        logic [PH_W-1:0]         w_x_in;
        logic [PH_W-1:0]         w_x2_in;
        t_side                   w_side;

        if (h == 0) begin : g_first
            assign w_acc_in = HORNER_TOP;
            assign w_x_in   = r_x2_x;
            assign w_x2_in  = r_x2;
            assign w_side   = r_x2_side;
        end else begin : g_next
            assign w_acc_in = r_hacc[h-1];
            assign w_x_in   = r_hx[h-1];
            assign w_x2_in  = r_hx2[h-1];
            assign w_side   = r_hside[h-1];
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_hacc[h]  <= mul_q30(w_acc_in, w_x2_in) + SIN_ADD[h];
                r_hx[h]    <= w_x_in;
                r_hx2[h]   <= w_x2_in;
                r_hside[h] <= w_side;
            end
        end
    end

    // Final multiply by x, clamp sine to 0..1
    assign w_s_full = mul_q30(r_hacc[HORNER_N-1], r_hx[HORNER_N-1]);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (w_s_full[ACC_W-1]) begin
                r_s <= '0;
            end else if (w_s_full[ACC_W-2:0] > Q30_VAL) begin
                r_s <= Q30_VAL;
            end else begin
                r_s <= w_s_full[PH_W-1:0];
            end
            r_s_side <= r_hside[HORNER_N-1];
        end
    end

    // Ease-in grows as 1 - cos
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_v      <= (r_s_side.seg == SEG_IN) ? (Q30_VAL - r_s) : r_s;
            r_v_side <= r_s_side;
        end
    end

    // Scale by segment fraction, then by 2/pi
    assign w_e1p = r_v_side.scale * r_v;
    assign w_e2p = r_e1 * K_2PI;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_e1      <= DIST_W'(w_e1p >> EASE_SH);
            r_e1_side <= r_v_side;
            r_e2      <= DIST_W'(w_e2p >> K_W);
            r_e2_side <= r_e1_side;
        end
    end

    // Total distance travelled
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dist <= r_e2_side.base + ((r_e2_side.seg == SEG_MID) ? '0 : r_e2);
        end
    end

    // Progress divider: (dist * 2^16 + total/2) / total, one bit per stage
    assign w_num = {r_dist, {FRAC_BITS{1'b0}}} + N_W'(r_total >> 1);

    for (genvar j = 0; j < FDIV_N; j++) begin : g_fdiv
        logic [DIST_W-1:0] w_rem_in;
        logic [FDIV_N-1:0] w_nlo_in;
        logic [FDIV_N-1:0] w_q_in;
        logic [DIST_W:0]   w_sh;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = DIST_W'(w_num >> FDIV_N);
            assign w_nlo_in = w_num[FDIV_N-1:0];
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_fd_rem[j-1];
            assign w_nlo_in = r_fd_nlo[j-1];
            assign w_q_in   = r_fd_q[j-1];
        end

        assign w_sh = {w_rem_in, w_nlo_in[FDIV_N-1]};
        assign w_ge = w_sh >= {1'b0, r_total};

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_fd_rem[j] <= w_ge ? DIST_W'(w_sh - {1'b0, r_total}) : DIST_W'(w_sh);
                r_fd_nlo[j] <= {w_nlo_in[FDIV_N-2:0], 1'b0};
                r_fd_q[j]   <= {w_q_in[FDIV_N-2:0], w_ge};
            end
        end
    end

    // Output register, saturate to one
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= (r_fd_q[FDIV_N-1] > ONE_VAL) ? ONE_VAL : r_fd_q[FDIV_N-1];
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = TDATA_W'(r_out);

    // Phase divider operands stay within a quarter period
    `ASSERT_NEVER(a_phase_num, r_vld[1] && (r1_side.seg != SEG_MID) && (r1_num > r1_den))
    `ASSERT_CLK(a_phase_den, (r_vld[1] && (r1_side.seg != SEG_MID)) |-> (r1_den != '0))
    // Progress division leaves a proper remainder
    `ASSERT_CLK(a_fdiv_rem, r_vld[ST_OUT-1] |-> (r_fd_rem[FDIV_N-1] < r_total))
    // Eased sine term stays within 0..1
    `ASSERT_CLK(a_sine_rng, r_vld[ST_E1-1] |-> (r_v <= Q30_VAL))
    `ASSERT_CLK(a_prog_rng, m_axis_tvalid |-> (m_axis_tdata[T_W-1:0] <= ONE_VAL))

endmodule

>>> tb/sv/tb_ease_in_out_curve_core.sv
// Testbench of the ease-in/ease-out curve core: random and directed times against a predictor
module tb_ease_in_out_curve_core import eioc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;

    // Expected progress values and the predictor of the curve
    class progress_scoreboard;
        logic [CFG_W-1:0] ease_in;
        logic [CFG_W-1:0] ease_out;
        logic [T_W-1:0]   pending[$];
        int               errors;

        function new();
            ease_in  = '0;
            ease_out = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_IDX_EASE_IN) begin
                ease_in = value;
            end else if (idx == CFG_IDX_EASE_OUT) begin
                ease_out = value;
            end
        endfunction

        // Q30 product, truncated toward zero
        function longint mul30(longint x, longint y);
            bit                neg;
            longint unsigned   mx;
            longint unsigned   my;
            longint unsigned   p;
            neg = (x < 0) != (y < 0);
            mx  = (x < 0) ? -x : x;
            my  = (y < 0) ? -y : y;
            p   = (mx * my) >> 30;
            return neg ? -longint'(p) : longint'(p);
        endfunction

        // sin(x*pi/2) with x and result in Q30
        function longint quarter_sin(longint x);
            longint coef[7];
            longint x2;
            longint acc;
            coef = '{1686629713, 693598668, 85569306, 5026995, 172272, 3864, 61};
            if (x < 0) x = 0;
            if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
            x2  = mul30(x, x);
            acc = coef[6];
            acc = mul30(acc, x2) - coef[5];
            acc = mul30(acc, x2) + coef[4];
            acc = mul30(acc, x2) - coef[3];
            acc = mul30(acc, x2) + coef[2];
            acc = mul30(acc, x2) - coef[1];
            acc = mul30(acc, x2) + coef[0];
            acc = mul30(acc, x);
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
            return acc;
        endfunction

        function logic [T_W-1:0] predict(logic [T_W-1:0] t_in);
            longint unsigned one_v;
            longint unsigned k;
            longint unsigned a;
            longint unsigned b;
            longint unsigned t;
            longint unsigned accel;
            longint unsigned decel;
            longint unsigned lin;
            longint unsigned total;
            longint unsigned dist_v;
            longint unsigned u;
            longint unsigned w;
            longint unsigned res;
            one_v = 64'd1 << 16;
            k     = 64'd10680707;
            a     = (ease_in > HALF_VAL) ? HALF_VAL : ease_in;
            b     = (ease_out > HALF_VAL) ? HALF_VAL : ease_out;
            t     = (t_in > one_v) ? one_v : t_in;
            accel = (a * k) >> 10;
            decel = (b * k) >> 10;
            lin   = (one_v - a - b) << 14;
            total = accel + lin + decel;
            if (t < a) begin
                u      = (t << 30) / a;
                w      = (64'd1 << 30) - quarter_sin((64'sd1 << 30) - longint'(u));
                dist_v = (((a * w) >> 16) * k) >> 24;
            end else if (t > one_v - b) begin
                u      = ((t - (one_v - b)) << 30) / b;
                w      = quarter_sin(longint'(u));
                dist_v = accel + lin + ((((b * w) >> 16) * k) >> 24);
            end else begin
                dist_v = accel + ((t - a) << 14);
            end
            if (total == 0) begin
                res = one_v;
            end else begin
                res = ((dist_v << 16) + (total >> 1)) / total;
                if (res > one_v) res = one_v;
            end
            return res[T_W-1:0];
        endfunction

        function void note_time(logic [T_W-1:0] t);
            pending.push_back(predict(t));
        endfunction

        function void check(logic [T_W-1:0] got);
            logic [T_W-1:0] exp_v;
            if (pending.size() == 0) begin
                $error("progress: no item expected, got %0d", got);
                errors++;
            end else begin
                exp_v = pending.pop_front();
                if (got !== exp_v) begin
                    $error("progress: expected %0d, got %0d", exp_v, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    progress_scoreboard sb = new();
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;
    int  stall_mode = 0;
    int  idle_cycles = 0;
    int  cyc = 0;

    ease_in_out_curve_core u_top (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Drain results and stall the receiver on a per-phase pattern
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata[T_W-1:0]);
            case (stall_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 99) >= 30);
                end
                default: begin
                    m_axis_tready <= (cyc % 7) >= 2;
                end
            endcase
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Send one time sample; bursts with random gaps when sender gaps are enabled
    task automatic send_time(logic [T_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(t);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_time(t);
    endtask

    // Write one register while no item is in flight
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Edge times around segment borders, then random times
    task automatic run_phase(int n_rand, bit hold_mid);
        int a;
        int b;
        a = int'((sb.ease_in > HALF_VAL) ? HALF_VAL : sb.ease_in);
        b = int'((sb.ease_out > HALF_VAL) ? HALF_VAL : sb.ease_out);
        send_time(T_W'(0));
        if (a > 0) send_time(T_W'(a - 1));
        send_time(T_W'(a));
        send_time(T_W'(a + 1));
        send_time(T_W'(65536 - b));
        send_time(T_W'(65537 - b));
        send_time(T_W'(65535));
        send_time(T_W'(65536));
        send_time(T_W'(65537));
        send_time('1);
        for (int i = 0; i < n_rand; i++) begin
            if (hold_mid && i == n_rand / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                wait_drained();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_time(T_W'($urandom));
            end else begin
                send_time(T_W'($urandom_range(0, 65536)));
            end
        end
    endtask

    initial begin
        int ins[10];
        int outs[10];
        ins  = '{0, 32768, 65535, 0, 1, 100, 40000, 16384, 0, 0};
        outs = '{0, 32768, 0, 65535, 1, 32768, 20000, 8192, 0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state is a straight line
        stall_mode  = 0;
        sender_gaps = 1'b0;
        run_phase(150, 1'b0);

        for (int p = 1; p < 10; p++) begin
            if (p < 8) begin
                write_reg(CFG_IDX_EASE_IN, CFG_W'(ins[p]));
                write_reg(CFG_IDX_EASE_OUT, CFG_W'(outs[p]));
            end else begin
                ins[p]  = $urandom_range(0, 65535);
                outs[p] = $urandom_range(0, 32768);
                write_reg(CFG_IDX_EASE_IN, CFG_W'(ins[p]));
                write_reg(CFG_IDX_EASE_OUT, CFG_W'(outs[p]));
            end
            // unknown indexes must leave the curve alone
            if (p == 5) begin
                write_reg(IDX_W'(2), 16'hFFFF);
                write_reg(IDX_W'(255), 16'h1234);
            end
            stall_mode  = p % 3;
            sender_gaps = (p % 4) != 3;
            run_phase(170, p == 4);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/eioc_pkg.sv
hdl/ease_in_out_curve_core.sv
tb/sv/tb_ease_in_out_curve_core.sv
